// File: sv/stc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for the seconds-to-calendar converter
// Holds the packed-value selector codes, the reciprocal constants used for
// division by fixed divisors, the stage-to-stage field groups and the month
// boundary tables.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Packed-value selector codes.
    localparam logic [2:0] CMD_TIME  = 3'd0;
    localparam logic [2:0] CMD_DATE  = 3'd1;
    localparam logic [2:0] CMD_MONTH = 3'd2;
    localparam logic [2:0] CMD_YEAR  = 3'd3;

    // Calendar constants.
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
    localparam logic [8:0]  DAYS_LEAP      = 9'd366;
    localparam logic [8:0]  DAYS_COMMON    = 9'd365;
    localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd6;
    localparam logic [7:0]  CENTURY_YEAR   = 8'd100;

    // Reciprocals: floor(x / d) == (x * RECIP) >> SHIFT, exact over the
    // full input range of each use.
    // seconds[31:7] / 675 gives the day count.
    localparam logic [25:0] DAY_RECIP   = 26'd50903317;
    // seconds-of-day[16:4] / 225 gives the hour.
    localparam logic [13:0] HOUR_RECIP  = 14'd9321;
    // seconds-of-hour[11:2] / 15 gives the minute.
    localparam logic [10:0] MIN_RECIP   = 11'd1093;
    // days / 1461 gives the four-year cycle.
    localparam logic [16:0] CYCLE_RECIP = 17'd91868;
    // (days + 6) / 7 gives the week count.
    localparam logic [16:0] WEEK_RECIP  = 17'd74899;

    // Time-of-day fields passed to the output stage.
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } stc_clock_t;

    // Date fields passed to the output stage.
    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
        logic [2:0] wday;
    } stc_date_t;

    // One complete result as held in the output buffer.
    typedef struct packed {
        logic [18:0] packed_value;
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [4:0]  day_of_month;
        logic [3:0]  month_of_year;
        logic [7:0]  years_elapsed;
        logic [2:0]  weekday;
    } stc_result_t;

    // Day of year (from one) of the last day of month idx+1.
    function automatic logic [8:0] month_end(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        begin
            case (idx)
                4'd0:    base = 9'd31;
                4'd1:    base = 9'd59;
                4'd2:    base = 9'd90;
                4'd3:    base = 9'd120;
                4'd4:    base = 9'd151;
                4'd5:    base = 9'd181;
                4'd6:    base = 9'd212;
                4'd7:    base = 9'd243;
                4'd8:    base = 9'd273;
                4'd9:    base = 9'd304;
                4'd10:   base = 9'd334;
                default: base = 9'd365;
            endcase
            // A leap February pushes every later boundary out by one day.
            if (leap && (idx != 4'd0))
            begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

    // Days in the year before the first day of the given month (1..13).
    function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
        logic [8:0] start;
        begin
            if (month <= 4'd1)
            begin
                start = 9'd0;
            end
            else
            begin
                start = month_end(month - 4'd2, leap);
            end
            return start;
        end
    endfunction

endpackage

// File: sv/stc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_if: valid/ready channels of the seconds-to-calendar converter
// stc_req_if carries one timestamp and selector per transaction; stc_rsp_if
// carries one converted result per transaction.
// ----------------------------------------------------------------------------
interface stc_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_count;
    logic [2:0]  cmd;

    modport source (output valid, output seconds_count, output cmd, input ready);
    modport sink   (input valid, input seconds_count, input cmd, output ready);
endinterface

interface stc_rsp_if;
    logic        valid;
    logic        ready;
    logic [18:0] packed_value;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_of_year;
    logic [7:0]  years_elapsed;
    logic [2:0]  weekday;

    modport source (
        output valid, output packed_value, output second_of_minute,
        output minute_of_hour, output hour_of_day, output day_of_month,
        output month_of_year, output years_elapsed, output weekday,
        input ready
    );
    modport sink (
        input valid, input packed_value, input second_of_minute,
        input minute_of_hour, input hour_of_day, input day_of_month,
        input month_of_year, input years_elapsed, input weekday,
        output ready
    );
endinterface

// File: sv/stc_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_split: splits a second count into whole days and seconds of the day
// Stages 1 to 3: input register, reciprocal multiply for the day count,
// then the remainder within the day.
// ----------------------------------------------------------------------------
module stc_split (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] seconds_count,
    output logic [15:0] days,
    output logic [16:0] in_day
);

    logic [31:0] secs_s1_reg;
    logic [31:0] secs_s1_next;
    logic [31:0] secs_s2_reg;
    logic [31:0] secs_s2_next;
    logic [15:0] days_s2_reg;
    logic [15:0] days_s2_next;
    logic [15:0] days_s3_reg;
    logic [15:0] days_s3_next;
    logic [16:0] in_day_s3_reg;
    logic [16:0] in_day_s3_next;
    logic [50:0] day_prod;
    logic [31:0] day_secs;

    // Stage 1 captures the incoming count.
    assign secs_s1_next = seconds_count;

    // Stage 2: days = seconds / 86400, as (seconds >> 7) / 675.
    assign day_prod     = 51'(secs_s1_reg[31:7]) * 51'(stc_pkg::DAY_RECIP);
    assign days_s2_next = day_prod[50:35];
    assign secs_s2_next = secs_s1_reg;

    // Stage 3: seconds left over within the day.
    assign day_secs       = 32'(days_s2_reg) * 32'(stc_pkg::SECS_PER_DAY);
    assign in_day_s3_next = 17'(secs_s2_reg - day_secs);
    assign days_s3_next   = days_s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            secs_s1_reg   <= secs_s1_next;
            secs_s2_reg   <= secs_s2_next;
            days_s2_reg   <= days_s2_next;
            days_s3_reg   <= days_s3_next;
            in_day_s3_reg <= in_day_s3_next;
        end
    end

    assign days   = days_s3_reg;
    assign in_day = in_day_s3_reg;

endmodule

// File: sv/stc_clock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_clock: hour, minute and second from the seconds of the day
// Stages 4 to 8: hour by reciprocal multiply, remainder in the hour, minute
// by reciprocal multiply, remainder in the minute, then an alignment stage.
// ----------------------------------------------------------------------------
module stc_clock (
    input  logic               clk,
    input  logic               en,
    input  logic [16:0]        in_day,
    output stc_pkg::stc_clock_t clock_fields
);

    logic [16:0] in_day_s4_reg;
    logic [16:0] in_day_s4_next;
    logic [4:0]  hour_s4_reg;
    logic [4:0]  hour_s4_next;
    logic [11:0] rem_s5_reg;
    logic [11:0] rem_s5_next;
    logic [4:0]  hour_s5_reg;
    logic [4:0]  hour_s5_next;
    logic [11:0] rem_s6_reg;
    logic [11:0] rem_s6_next;
    logic [5:0]  minute_s6_reg;
    logic [5:0]  minute_s6_next;
    logic [4:0]  hour_s6_reg;
    logic [4:0]  hour_s6_next;
    stc_pkg::stc_clock_t clock_s7_reg;
    stc_pkg::stc_clock_t clock_s7_next;
    stc_pkg::stc_clock_t clock_s8_reg;
    stc_pkg::stc_clock_t clock_s8_next;
    logic [26:0] hour_prod;
    logic [16:0] hour_secs;
    logic [20:0] minute_prod;
    logic [11:0] minute_secs;

    // Stage 4: hour = seconds_of_day / 3600, as (x >> 4) / 225.
    assign hour_prod      = 27'(in_day[16:4]) * 27'(stc_pkg::HOUR_RECIP);
    assign hour_s4_next   = hour_prod[25:21];
    assign in_day_s4_next = in_day;

    // Stage 5: seconds within the hour.
    assign hour_secs    = 17'(hour_s4_reg) * 17'(stc_pkg::SECS_PER_HOUR);
    assign rem_s5_next  = 12'(in_day_s4_reg - hour_secs);
    assign hour_s5_next = hour_s4_reg;

    // Stage 6: minute = seconds_of_hour / 60, as (x >> 2) / 15.
    assign minute_prod    = 21'(rem_s5_reg[11:2]) * 21'(stc_pkg::MIN_RECIP);
    assign minute_s6_next = minute_prod[19:14];
    assign rem_s6_next    = rem_s5_reg;
    assign hour_s6_next   = hour_s5_reg;

    // Stage 7: seconds within the minute.
    assign minute_secs = 12'(minute_s6_reg) * 12'(stc_pkg::SECS_PER_MIN);
    always_comb
    begin
        clock_s7_next.hour   = hour_s6_reg;
        clock_s7_next.minute = minute_s6_reg;
        clock_s7_next.second = 6'(rem_s6_reg - minute_secs);
    end

    // Stage 8 lines the time fields up with the date path.
    assign clock_s8_next = clock_s7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_day_s4_reg <= in_day_s4_next;
            hour_s4_reg   <= hour_s4_next;
            rem_s5_reg    <= rem_s5_next;
            hour_s5_reg   <= hour_s5_next;
            rem_s6_reg    <= rem_s6_next;
            minute_s6_reg <= minute_s6_next;
            hour_s6_reg   <= hour_s6_next;
            clock_s7_reg  <= clock_s7_next;
            clock_s8_reg  <= clock_s8_next;
        end
    end

    assign clock_fields = clock_s8_reg;

endmodule

// File: sv/stc_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_date: year, month, day of month and weekday from the day count
// Stages 4 to 8: four-year cycle and week quotient, their remainders, year
// and day of year, month by parallel boundary compares, then day of month.
// ----------------------------------------------------------------------------
module stc_date (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        days,
    output stc_pkg::stc_date_t date_fields
);

    logic [5:0]  cyc_s4_reg;
    logic [5:0]  cyc_s4_next;
    logic [13:0] wq_s4_reg;
    logic [13:0] wq_s4_next;
    logic [15:0] days_s4_reg;
    logic [15:0] days_s4_next;
    logic [10:0] rem_s5_reg;
    logic [10:0] rem_s5_next;
    logic [5:0]  cyc_s5_reg;
    logic [5:0]  cyc_s5_next;
    logic [2:0]  wday_s5_reg;
    logic [2:0]  wday_s5_next;
    logic [7:0]  year_s6_reg;
    logic [7:0]  year_s6_next;
    logic [8:0]  doy_s6_reg;
    logic [8:0]  doy_s6_next;
    logic [2:0]  wday_s6_reg;
    logic [2:0]  wday_s6_next;
    logic [3:0]  month_s7_reg;
    logic [3:0]  month_s7_next;
    logic [8:0]  t_s7_reg;
    logic [8:0]  t_s7_next;
    logic        leap_s7_reg;
    logic        leap_s7_next;
    logic [7:0]  year_s7_reg;
    logic [7:0]  year_s7_next;
    logic [2:0]  wday_s7_reg;
    logic [2:0]  wday_s7_next;
    stc_pkg::stc_date_t date_s8_reg;
    stc_pkg::stc_date_t date_s8_next;
    logic [32:0] cyc_prod;
    logic [32:0] wq_prod;
    logic [15:0] days_shift;
    logic [15:0] cyc_days;
    logic [15:0] wq_days;
    logic [10:0] rem_common;
    logic [1:0]  year_off;
    logic [10:0] off_days;
    logic [11:0] passed;

    // Stage 4: cycle = days / 1461 and weeks = (days + 6) / 7.
    assign days_shift   = days + 16'(stc_pkg::EPOCH_WEEKDAY);
    assign cyc_prod     = 33'(days) * 33'(stc_pkg::CYCLE_RECIP);
    assign wq_prod      = 33'(days_shift) * 33'(stc_pkg::WEEK_RECIP);
    assign cyc_s4_next  = cyc_prod[32:27];
    assign wq_s4_next   = wq_prod[32:19];
    assign days_s4_next = days;

    // Stage 5: day within the cycle and weekday.
    assign cyc_days     = 16'(cyc_s4_reg) * 16'(stc_pkg::DAYS_PER_CYCLE);
    assign wq_days      = 16'(wq_s4_reg) * 16'd7;
    assign rem_s5_next  = 11'(days_s4_reg - cyc_days);
    assign wday_s5_next = 3'(days_s4_reg + 16'(stc_pkg::EPOCH_WEEKDAY) - wq_days);
    assign cyc_s5_next  = cyc_s4_reg;

    // Stage 6: the first year of a cycle is 366 days, the other three 365.
    assign rem_common = rem_s5_reg - 11'(stc_pkg::DAYS_LEAP);
    always_comb
    begin
        if (rem_common >= 11'd730)
        begin
            year_off = 2'd2;
            off_days = 11'd730;
        end
        else if (rem_common >= 11'(stc_pkg::DAYS_COMMON))
        begin
            year_off = 2'd1;
            off_days = 11'(stc_pkg::DAYS_COMMON);
        end
        else
        begin
            year_off = 2'd0;
            off_days = 11'd0;
        end

        if (rem_s5_reg < 11'(stc_pkg::DAYS_LEAP))
        begin
            year_s6_next = {cyc_s5_reg, 2'b00};
            doy_s6_next  = 9'(rem_s5_reg);
        end
        else
        begin
            year_s6_next = {cyc_s5_reg, 2'b00} + 8'd1 + 8'(year_off);
            doy_s6_next  = 9'(rem_common - off_days);
        end
    end
    assign wday_s6_next = wday_s5_reg;

    // Stage 7: month from the count of month ends already passed.
    // Gregorian leap test; within this year range only year 100 is a
    // multiple of four that is not a leap year.
    assign leap_s7_next = (year_s6_reg[1:0] == 2'b00) && (year_s6_reg != stc_pkg::CENTURY_YEAR);
    assign t_s7_next    = doy_s6_reg + 9'd1;
    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            passed[i] = (t_s7_next > stc_pkg::month_end(4'(i), leap_s7_next));
        end
        month_s7_next = 4'd1;
        for (int i = 0; i < 12; i++)
        begin
            month_s7_next = month_s7_next + 4'(passed[i]);
        end
    end
    assign year_s7_next = year_s6_reg;
    assign wday_s7_next = wday_s6_reg;

    // Stage 8: day of month. A 366-day year without a leap February ends in
    // a thirteenth month of one day.
    always_comb
    begin
        date_s8_next.day   = 5'(t_s7_reg - stc_pkg::month_start(month_s7_reg, leap_s7_reg));
        date_s8_next.month = month_s7_reg;
        date_s8_next.year  = year_s7_reg;
        date_s8_next.wday  = wday_s7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cyc_s4_reg   <= cyc_s4_next;
            wq_s4_reg    <= wq_s4_next;
            days_s4_reg  <= days_s4_next;
            rem_s5_reg   <= rem_s5_next;
            cyc_s5_reg   <= cyc_s5_next;
            wday_s5_reg  <= wday_s5_next;
            year_s6_reg  <= year_s6_next;
            doy_s6_reg   <= doy_s6_next;
            wday_s6_reg  <= wday_s6_next;
            month_s7_reg <= month_s7_next;
            t_s7_reg     <= t_s7_next;
            leap_s7_reg  <= leap_s7_next;
            year_s7_reg  <= year_s7_next;
            wday_s7_reg  <= wday_s7_next;
            date_s8_reg  <= date_s8_next;
        end
    end

    assign date_fields = date_s8_reg;

endmodule

// File: sv/stc_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pack: packed value selection and output skid buffer
// Forms the decimal-packed value chosen by cmd, writes the finished result
// into a two-entry buffer and drives the result channel. The pipeline
// advances whenever the buffer has a free entry.
// ----------------------------------------------------------------------------
module stc_pack (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          cmd,
    input  logic                zero_count,
    input  stc_pkg::stc_clock_t clock_fields,
    input  stc_pkg::stc_date_t  date_fields,
    output logic                en,
    stc_rsp_if.source           rsp
);

    stc_pkg::stc_result_t buf_reg [2];
    stc_pkg::stc_result_t entry_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    logic [18:0] time_value;
    logic [18:0] date_value;
    logic [18:0] sel_value;

    // Decimal packing: HHMMSS and DDMMYY.
    assign time_value = 19'(clock_fields.hour) * 19'd10000
                      + 19'(clock_fields.minute) * 19'd100
                      + 19'(clock_fields.second);
    assign date_value = 19'(date_fields.day) * 19'd10000
                      + 19'(date_fields.month) * 19'd100
                      + 19'(date_fields.year);

    always_comb
    begin
        unique case (cmd)
            stc_pkg::CMD_TIME:  sel_value = time_value;
            stc_pkg::CMD_DATE:  sel_value = date_value;
            stc_pkg::CMD_MONTH: sel_value = 19'(date_fields.month);
            stc_pkg::CMD_YEAR:  sel_value = 19'(date_fields.year);
            default:            sel_value = 19'd0;
        endcase
    end

    // A zero count gives a zero packed value for every selector.
    always_comb
    begin
        entry_next.packed_value     = zero_count ? 19'd0 : sel_value;
        entry_next.second_of_minute = clock_fields.second;
        entry_next.minute_of_hour   = clock_fields.minute;
        entry_next.hour_of_day      = clock_fields.hour;
        entry_next.day_of_month     = date_fields.day;
        entry_next.month_of_year    = date_fields.month;
        entry_next.years_elapsed    = date_fields.year;
        entry_next.weekday          = date_fields.wday;
    end

    // Buffer control.
    assign en          = ~count_reg[1];
    assign push        = en & in_valid;
    assign pop         = rsp.valid & rsp.ready;
    assign wr_ptr_next = wr_ptr_reg ^ push;
    assign rd_ptr_next = rd_ptr_reg ^ pop;
    assign count_next  = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Buffer storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= entry_next;
        end
    end

    // Result channel.
    assign rsp.valid            = (count_reg != 2'd0);
    assign rsp.packed_value     = buf_reg[rd_ptr_reg].packed_value;
    assign rsp.second_of_minute = buf_reg[rd_ptr_reg].second_of_minute;
    assign rsp.minute_of_hour   = buf_reg[rd_ptr_reg].minute_of_hour;
    assign rsp.hour_of_day      = buf_reg[rd_ptr_reg].hour_of_day;
    assign rsp.day_of_month     = buf_reg[rd_ptr_reg].day_of_month;
    assign rsp.month_of_year    = buf_reg[rd_ptr_reg].month_of_year;
    assign rsp.years_elapsed    = buf_reg[rd_ptr_reg].years_elapsed;
    assign rsp.weekday          = buf_reg[rd_ptr_reg].weekday;

    // The buffer never holds more than two transactions.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // Occupancy follows pushes and pops.
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("output buffer count lost a push");

    // Time-of-day fields reaching the buffer are in range.
    a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (clock_fields.hour <= 5'd23 && clock_fields.minute <= 6'd59
                      && clock_fields.second <= 6'd59))
        else $error("time of day out of range");

    // Date fields reaching the buffer are in range.
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (date_fields.month >= 4'd1 && date_fields.month <= 4'd13
                      && date_fields.day >= 5'd1 && date_fields.wday <= 3'd6
                      && date_fields.year <= 8'd136))
        else $error("date out of range");

endmodule

// File: sv/seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_top: epoch seconds to time of day, date and weekday
// Converts a 32-bit second count since year zero into calendar fields and
// one decimal-packed value selected by cmd.
// ----------------------------------------------------------------------------
// Usage:
//   req carries seconds_count and cmd; a transaction completes when valid
//   and ready are both high. rsp carries the packed value and the calendar
//   fields with the same handshake, one result per request, in order.
//   A request passes through eight pipeline stages (day split, hour and
//   cycle quotients, remainders, year, month, day of month) and a write
//   into a two-entry output buffer before rsp.valid goes high.
//   Throughput is one transaction per cycle while the buffer has a free
//   entry: no stage chains more than one multiply, so a new request can
//   enter every clock unless the pipeline holds.
//   When the receiver holds rsp.ready low the buffer absorbs results; once
//   both entries are full the whole pipeline holds and req.ready drops,
//   and no transaction is lost or repeated. Bubbles still drain into the
//   buffer while it has room.
//   Reset clears the stage valid bits and the buffer; the block has no
//   state between transactions and takes requests right after reset.
// ----------------------------------------------------------------------------
module seconds_to_calendar_top (
    input  logic      clk,
    input  logic      rst_n,
    stc_req_if.sink   req,
    stc_rsp_if.source rsp
);

    localparam int STAGES = 8;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [2:0]        cmd_reg  [STAGES];
    logic [2:0]        cmd_next [STAGES];
    logic [STAGES-1:0] zero_reg;
    logic [STAGES-1:0] zero_next;
    logic              en;
    logic [15:0]       days;
    logic [16:0]       in_day;
    stc_pkg::stc_clock_t clock_fields;
    stc_pkg::stc_date_t  date_fields;

    assign req.ready = en;

    // Valid bits, selector and zero flag travel alongside the data stages.
    always_comb
    begin
        valid_next[0] = req.valid;
        cmd_next[0]   = req.cmd;
        zero_next[0]  = (req.seconds_count == 32'd0);
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = valid_reg[i-1];
            cmd_next[i]   = cmd_reg[i-1];
            zero_next[i]  = zero_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg  <= cmd_next;
            zero_reg <= zero_next;
        end
    end

    // Stages 1 to 3.
    stc_split u_split (
        .clk           (clk),
        .en            (en),
        .seconds_count (req.seconds_count),
        .days          (days),
        .in_day        (in_day)
    );

    // Stages 4 to 8, time of day.
    stc_clock u_clock (
        .clk          (clk),
        .en           (en),
        .in_day       (in_day),
        .clock_fields (clock_fields)
    );

    // Stages 4 to 8, date and weekday.
    stc_date u_date (
        .clk         (clk),
        .en          (en),
        .days        (days),
        .date_fields (date_fields)
    );

    // Packing and output buffer.
    stc_pack u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (valid_reg[STAGES-1]),
        .cmd          (cmd_reg[STAGES-1]),
        .zero_count   (zero_reg[STAGES-1]),
        .clock_fields (clock_fields),
        .date_fields  (date_fields),
        .en           (en),
        .rsp          (rsp)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the seconds-to-calendar converter
// A table of directed timestamps runs first, then about six hundred random
// timestamps aimed at day, year and century boundaries. Each result is
// compared field by field against an in-bench calendar computation, in order,
// while both channels stall in short random bursts, except in a final steady run.
// ----------------------------------------------------------------------------
module testbench;

    // Selector codes that produce no packed value.
    localparam logic [2:0] CMD_NONE  = 3'd4;
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS   = 625;
    localparam int STEADY_ITEMS   = 100;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    // Day ranges used to steer random timestamps.
    localparam int unsigned LAST_DAY        = 49710;
    localparam int unsigned YEAR_100_FIRST  = 36525;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        logic [31:0]          secs;
        logic [2:0]           sel;
        bit                   fixed;
        stc_pkg::stc_result_t result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    stc_req_if req_ch ();
    stc_rsp_if rsp_ch ();

    seconds_to_calendar_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    stc_pkg::stc_result_t pending_results [$];
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          century_end_hits;
    int          idle_cycles;
    int          stall_left;
    bit          steady_phase;

    // Builds a result whose fields can be read straight off the timestamp.
    function automatic stc_pkg::stc_result_t known_result(
        input int unsigned pv, input int unsigned sec, input int unsigned mins,
        input int unsigned hr, input int unsigned dom, input int unsigned mon,
        input int unsigned yr, input int unsigned wd
    );
        stc_pkg::stc_result_t res;
        res.packed_value     = pv[18:0];
        res.second_of_minute = sec[5:0];
        res.minute_of_hour   = mins[5:0];
        res.hour_of_day      = hr[4:0];
        res.day_of_month     = dom[4:0];
        res.month_of_year    = mon[3:0];
        res.years_elapsed    = yr[7:0];
        res.weekday          = wd[2:0];
        return res;
    endfunction

    localparam stc_pkg::stc_result_t AT_EPOCH = '{
        packed_value: 19'd0, second_of_minute: 6'd0, minute_of_hour: 6'd0,
        hour_of_day: 5'd0, day_of_month: 5'd1, month_of_year: 4'd1,
        years_elapsed: 8'd0, weekday: stc_pkg::EPOCH_WEEKDAY
    };

    // Calendar conversion of one timestamp, including the packed selector.
    function automatic stc_pkg::stc_result_t convert_timestamp(
        input logic [31:0] secs, input logic [2:0] sel
    );
        stc_pkg::stc_result_t res;
        int unsigned day_secs;
        int unsigned day_count;
        int unsigned cycle_day;
        int unsigned year_num;
        int unsigned day_left;
        int unsigned mon;
        int unsigned mon_len;
        int unsigned hr;
        int unsigned mins;
        int unsigned sec;
        int unsigned pv;
        bit          feb_long;
        day_secs  = secs % 86400;
        day_count = secs / 86400;
        hr        = day_secs / 3600;
        mins      = (day_secs % 3600) / 60;
        sec       = day_secs % 60;

        // Four-year cycles, with the leap year first in each cycle.
        cycle_day = day_count % 1461;
        if (cycle_day < 366)
        begin
            year_num = (day_count / 1461) * 4;
            day_left = cycle_day + 1;
        end
        else
        begin
            year_num = (day_count / 1461) * 4 + 1 + (cycle_day - 366) / 365;
            day_left = (cycle_day - 366) % 365 + 1;
        end

        // February follows the Gregorian rule, so year 100 can spill into month 13.
        feb_long = (year_num % 400 == 0) || ((year_num % 4 == 0) && (year_num % 100 != 0));
        mon      = 1;
        mon_len  = MONTH_DAYS[0];
        while ((mon <= 12) && (day_left > mon_len))
        begin
            day_left = day_left - mon_len;
            mon      = mon + 1;
            if (mon <= 12)
            begin
                mon_len = ((mon == 2) && feb_long) ? 29 : MONTH_DAYS[mon - 1];
            end
        end

        case (sel)
            stc_pkg::CMD_TIME:  pv = hr * 10000 + mins * 100 + sec;
            stc_pkg::CMD_DATE:  pv = day_left * 10000 + mon * 100 + year_num;
            stc_pkg::CMD_MONTH: pv = mon;
            stc_pkg::CMD_YEAR:  pv = year_num;
            default:            pv = 0;
        endcase

        res = known_result(pv, sec, mins, hr, day_left, mon, year_num, (day_count + 6) % 7);
        if (secs == 32'd0)
        begin
            res = AT_EPOCH;
        end
        return res;
    endfunction

    // Directed timestamps: the epoch, the selector codes, leap days, the
    // century year whose last day lands in month 13, and the top of the range.
    stim_row_t directed_rows [26] = '{
        '{32'd0, stc_pkg::CMD_TIME,  1'b1, AT_EPOCH},
        '{32'd0, stc_pkg::CMD_DATE,  1'b1, AT_EPOCH},
        '{32'd0, stc_pkg::CMD_MONTH, 1'b1, AT_EPOCH},
        '{32'd0, stc_pkg::CMD_YEAR,  1'b1, AT_EPOCH},
        '{32'd0, CMD_NONE,  1'b1, AT_EPOCH},
        '{32'd0, CMD_RSVD7, 1'b1, AT_EPOCH},
        '{32'd1, stc_pkg::CMD_TIME,  1'b1, known_result(1, 1, 0, 0, 1, 1, 0, 6)},
        '{32'd1, stc_pkg::CMD_DATE,  1'b1, known_result(10100, 1, 0, 0, 1, 1, 0, 6)},
        '{32'd86399, stc_pkg::CMD_TIME, 1'b1, known_result(235959, 59, 59, 23, 1, 1, 0, 6)},
        '{32'd86400, stc_pkg::CMD_DATE, 1'b0, '0},
        '{32'd5097600, stc_pkg::CMD_DATE, 1'b0, '0},
        '{32'd31622400, stc_pkg::CMD_YEAR, 1'b0, '0},
        '{32'd131328000, stc_pkg::CMD_DATE, 1'b0, '0},
        '{32'd3155673600, stc_pkg::CMD_DATE, 1'b0, '0},
        '{32'd3160771200, stc_pkg::CMD_DATE, 1'b0, '0},
        '{32'd3160857600, stc_pkg::CMD_MONTH, 1'b0, '0},
        '{32'd3187296000, stc_pkg::CMD_DATE, 1'b0, '0},
        '{32'd3187382399, stc_pkg::CMD_MONTH, 1'b0, '0},
        '{32'd3187382400, stc_pkg::CMD_YEAR, 1'b0, '0},
        '{32'hFFFF_FFFF, stc_pkg::CMD_TIME, 1'b0, '0},
        '{32'hFFFF_FFFF, stc_pkg::CMD_DATE, 1'b0, '0},
        '{32'hFFFF_FFFF, CMD_RSVD5, 1'b0, '0},
        '{32'hFFFF_FFFF, CMD_RSVD6, 1'b0, '0},
        '{32'hFFFF_FFFE, CMD_NONE, 1'b0, '0},
        '{32'h8000_0000, stc_pkg::CMD_YEAR, 1'b0, '0},
        '{32'h7FFF_FFFF, stc_pkg::CMD_MONTH, 1'b0, '0}
    };

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Prints one mismatching field and counts it.
    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // Compares one received transaction with the oldest outstanding prediction.
    task automatic check_result();
        stc_pkg::stc_result_t want;
        if (pending_results.size() == 0)
        begin
            $display("[%0t] result transaction with nothing outstanding", $time);
            mismatch_count = mismatch_count + 1;
        end
        else
        begin
            want = pending_results.pop_front();
            results_checked = results_checked + 1;
            if (rsp_ch.packed_value !== want.packed_value)
                report_mismatch("packed_value", 32'(rsp_ch.packed_value),
                                32'(want.packed_value));
            if (rsp_ch.second_of_minute !== want.second_of_minute)
                report_mismatch("second_of_minute", 32'(rsp_ch.second_of_minute),
                                32'(want.second_of_minute));
            if (rsp_ch.minute_of_hour !== want.minute_of_hour)
                report_mismatch("minute_of_hour", 32'(rsp_ch.minute_of_hour),
                                32'(want.minute_of_hour));
            if (rsp_ch.hour_of_day !== want.hour_of_day)
                report_mismatch("hour_of_day", 32'(rsp_ch.hour_of_day),
                                32'(want.hour_of_day));
            if (rsp_ch.day_of_month !== want.day_of_month)
                report_mismatch("day_of_month", 32'(rsp_ch.day_of_month),
                                32'(want.day_of_month));
            if (rsp_ch.month_of_year !== want.month_of_year)
                report_mismatch("month_of_year", 32'(rsp_ch.month_of_year),
                                32'(want.month_of_year));
            if (rsp_ch.years_elapsed !== want.years_elapsed)
                report_mismatch("years_elapsed", 32'(rsp_ch.years_elapsed),
                                32'(want.years_elapsed));
            if (rsp_ch.weekday !== want.weekday)
                report_mismatch("weekday", 32'(rsp_ch.weekday), 32'(want.weekday));
        end
    endtask

    // Result side: check each transaction and stall ready in short bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                check_result();
            end
            if (steady_phase)
            begin
                rsp_ch.ready <= 1'b1;
                stall_left   <= 0;
            end
            else if (stall_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= $urandom_range(0, 2);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog expired with %0d results outstanding",
                         $time, pending_results.size());
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offers one timestamp, waits for acceptance and records the prediction.
    task automatic send_timestamp(input logic [31:0] secs, input logic [2:0] sel,
                                  input stc_pkg::stc_result_t want);
        req_ch.valid         <= 1'b1;
        req_ch.seconds_count <= secs;
        req_ch.cmd           <= sel;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        pending_results.push_back(want);
        if (want.month_of_year == 4'd13)
        begin
            century_end_hits = century_end_hits + 1;
        end
        // Occasional sender gap.
        if (!steady_phase && ($urandom_range(0, 3) == 0))
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Holds the request side until every outstanding result has come back.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random timestamp, biased toward day edges, year 100 and the range ends.
    function automatic logic [31:0] pick_timestamp();
        longint unsigned stamp;
        int unsigned     day_num;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                stamp = $urandom();
            end
            4, 5:
            begin
                day_num = $urandom_range(0, LAST_DAY - 1);
                stamp   = longint'(day_num) * 86400;
                if ($urandom_range(0, 1) == 0)
                    stamp = stamp + $urandom_range(0, 2);
                else
                    stamp = stamp + 86399 - $urandom_range(0, 2);
            end
            6:
            begin
                day_num = YEAR_100_FIRST + $urandom_range(0, 365);
                stamp   = longint'(day_num) * 86400 + $urandom_range(0, 86399);
            end
            7:
            begin
                stamp = longint'($urandom_range(0, LAST_DAY)) * 86400 + $urandom_range(0, 86399);
                if (stamp > 64'hFFFF_FFFF)
                begin
                    stamp = 64'hFFFF_FFFF - $urandom_range(0, 86399);
                end
            end
            8:
            begin
                stamp = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 200000);
            end
            default:
            begin
                stamp = 64'hFFFF_FFFF - $urandom_range(0, 10000000);
            end
        endcase
        return stamp[31:0];
    endfunction

    // Main stimulus sequence.
    initial
    begin
        logic [31:0] secs;
        logic [2:0]  sel;
        stc_pkg::stc_result_t want;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.seconds_count = 32'd0;
        req_ch.cmd           = stc_pkg::CMD_TIME;
        century_end_hits     = 0;
        steady_phase         = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].fixed)
                want = directed_rows[i].result;
            else
                want = convert_timestamp(directed_rows[i].secs, directed_rows[i].sel);
            send_timestamp(directed_rows[i].secs, directed_rows[i].sel, want);
        end
        wait_for_results();

        // Random timestamps, with one full drain midway and no idling at the end.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                wait_for_results();
            end
            if (n == RANDOM_ITEMS - STEADY_ITEMS)
            begin
                steady_phase <= 1'b1;
            end
            secs = pick_timestamp();
            sel  = 3'($urandom_range(0, 7));
            send_timestamp(secs, sel, convert_timestamp(secs, sel));
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d directed and %0d random timestamps, %0d results compared.",
                 $size(directed_rows), RANDOM_ITEMS, results_checked);
        $display("Month-13 days of year 100 seen: %0d; field mismatches: %0d.",
                 century_end_hits, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
